@@ rtl/absa_pkg.sv @@
package absa_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ACTIVE_FORCE   = 2'd0;
   localparam logic [1:0] CSR_PRESSURE_SCALE = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [31:0] ACTIVE_FORCE_RESET   = 32'd0;
   localparam logic [31:0] PRESSURE_SCALE_RESET = 32'd65536;

   // Saturation limits of a Q32.16 accumulator.
   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   // Mode codes of an input item.
   localparam logic MODE_BOND    = 1'b0;
   localparam logic MODE_READOUT = 1'b1;

   typedef logic signed [47:0] acc_type;

   typedef struct packed {
      logic               mode;
      logic [11:0]        atom_a;
      logic [11:0]        atom_b;
      logic signed [31:0] pos_ax;
      logic signed [31:0] pos_ay;
      logic signed [31:0] pos_bx;
      logic signed [31:0] pos_by;
      logic               in_group;
   } req_type;

   typedef struct packed {
      logic [11:0] out_atom;
      acc_type     stress_xy;
      acc_type     stress_yy;
      acc_type     stress_xx;
      acc_type     stress_yx;
   } rsp_type;

   // One entry of the stress store: four components.
   typedef struct packed {
      acc_type comp_a;
      acc_type comp_b;
      acc_type comp_c;
      acc_type comp_d;
   } entry_type;

   typedef enum logic [17:0] {
      ST_CLEAR = 18'b000000000000000001,
      ST_IDLE  = 18'b000000000000000010,
      ST_DIFF  = 18'b000000000000000100,
      ST_MUL   = 18'b000000000000001000,
      ST_SQGO  = 18'b000000000000010000,
      ST_SQRT  = 18'b000000000000100000,
      ST_DVGO  = 18'b000000000001000000,
      ST_DIV   = 18'b000000000010000000,
      ST_FMUL  = 18'b000000000100000000,
      ST_TERM  = 18'b000000001000000000,
      ST_RDA   = 18'b000000010000000000,
      ST_WRA   = 18'b000000100000000000,
      ST_RDB   = 18'b000001000000000000,
      ST_WRB   = 18'b000010000000000000,
      ST_RRD   = 18'b000100000000000000,
      ST_RMUL  = 18'b001000000000000000,
      ST_RFIN  = 18'b010000000000000000,
      ST_ROUT  = 18'b100000000000000000
   } state_type;

   // Saturating add of two Q32.16 values.
   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s > 49'sh0_7FFF_FFFF_FFFF) begin
         return ACC_MAX;
      end else if (s < -49'sh0_8000_0000_0000) begin
         return ACC_MIN;
      end
      return s[47:0];
   endfunction

   // Gives a magnitude its sign and saturates to 48 bits.
   function automatic acc_type sign_sat(input logic [63:0] m, input logic neg);
      if (neg) begin
         if (m >= 64'h0000_8000_0000_0000) begin
            return ACC_MIN;
         end
         return 48'(0 - m);
      end
      if (m > 64'h0000_7FFF_FFFF_FFFF) begin
         return ACC_MAX;
      end
      return m[47:0];
   endfunction

endpackage

@@ rtl/absa_store.sv @@
module absa_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  absa_pkg::entry_type   wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output absa_pkg::entry_type   rd_data
);

   absa_pkg::entry_type mem [DEPTH];
   absa_pkg::entry_type rd_data_ff;

   // Synchronous write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Synchronous read port; the read data is registered and appears in the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/absa_sqrt.sv @@
module absa_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [64:0] radicand,
   output logic        busy,
   output logic [32:0] root
);

   logic [65:0] rad_ff;
   logic [34:0] rem_ff;
   logic [32:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [36:0] shifted;
   logic [36:0] trial;
   logic        take;

   // One result bit per cycle: bring down two radicand bits and try the next root bit.
   assign shifted = {rem_ff, rad_ff[65:64]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign take    = (shifted >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {1'b0, radicand};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[63:0], 2'b00};
         if (take) begin
            rem_ff  <= 35'(shifted - trial);
            root_ff <= {root_ff[31:0], 1'b1};
         end else begin
            rem_ff  <= shifted[34:0];
            root_ff <= {root_ff[31:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

@@ rtl/absa_div.sv @@
module absa_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);

   logic [63:0] num_ff;
   logic [32:0] den_ff;
   logic [32:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [33:0] shifted;
   logic        take;

   // Restoring division, one quotient bit per cycle.
   assign shifted = {rem_ff, num_ff[63]};
   assign take    = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[62:0], take};
         if (take) begin
            rem_ff <= 33'(shifted - {1'b0, den_ff});
         end else begin
            rem_ff <= shifted[32:0];
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

@@ rtl/active_bond_stress_accumulator_core.sv @@
// Bond item: ready returns after the square root, the shared-divisor dividers and two
// read-modify-writes of the stress memory; a zero-length bond returns ready after the
// DIFF and MUL states. Readout item: RRD reads the entry, RMUL and RFIN scale and select,
// and ROUT registers the result; one item is worked at a time.
// The result register lets the next item be taken while a result waits.
// Reset is synchronous; afterwards a clearing pass zeroes the memory before the first item.
module active_bond_stress_accumulator_core #(
   parameter int MAX_ATOMS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  absa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output absa_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_ATOMS);

   absa_pkg::state_type state_ff, state_in;
   absa_pkg::req_type   item_ff;
   logic [31:0]         active_force_ff;
   logic [31:0]         pressure_scale_ff;
   logic [AW-1:0]       clr_cnt_ff;

   logic [31:0] ax_ff, ay_ff;
   logic        dxneg_ff, dyneg_ff;
   logic [63:0] sx_ff, sy_ff, pxy_ff;
   logic [63:0] plo_ff [3];
   logic [31:0] phi_ff [3];
   absa_pkg::acc_type txy_ff, tyy_ff, txx_ff, tyx_ff;

   absa_pkg::entry_type raw_ff;
   logic [63:0]         slo_ff [4];
   logic [47:0]         shi_ff [4];
   logic [3:0]          vneg_ff;
   absa_pkg::entry_type res_ff;

   logic              rsp_valid_ff;
   absa_pkg::rsp_type rsp_data_ff;

   logic [16:0]   a_ext, b_ext;
   logic          a_ok, b_ok;
   logic [AW-1:0] a_addr, b_addr;

   logic        sq_start, sq_busy;
   logic [32:0] sq_root;
   logic        dv_start;
   logic [2:0]  dv_busy;
   logic [63:0] quo [3];
   logic [63:0] dvnd [3];

   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   absa_pkg::entry_type mem_wr_data, mem_rd_data;

   logic [32:0] dx, dy;
   logic [31:0] fm, psm;
   logic        fneg, psneg, xyneg;
   logic [46:0] mxy, myy, mxx;
   logic [47:0] vmag [4];
   absa_pkg::acc_type vals [4];
   absa_pkg::acc_type scaled [4];
   logic [79:0] sprod [4];
   absa_pkg::entry_type upd;

   // Atom index range checks and memory addresses.
   assign a_ext  = {5'd0, item_ff.atom_a};
   assign b_ext  = {5'd0, item_ff.atom_b};
   assign a_ok   = (a_ext < 17'(MAX_ATOMS));
   assign b_ok   = (b_ext < 17'(MAX_ATOMS));
   assign a_addr = a_ext[AW-1:0];
   assign b_addr = b_ext[AW-1:0];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_force_ff   <= absa_pkg::ACTIVE_FORCE_RESET;
         pressure_scale_ff <= absa_pkg::PRESSURE_SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            absa_pkg::CSR_ACTIVE_FORCE:   active_force_ff   <= csr_wdata;
            absa_pkg::CSR_PRESSURE_SCALE: pressure_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         absa_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == AW'(MAX_ATOMS - 1)) state_in = absa_pkg::ST_IDLE;
         end
         absa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.mode == absa_pkg::MODE_READOUT) ?
                          absa_pkg::ST_RRD : absa_pkg::ST_DIFF;
            end
         end
         absa_pkg::ST_DIFF: state_in = absa_pkg::ST_MUL;
         absa_pkg::ST_MUL: begin
            // A zero-length bond adds nothing.
            state_in = (ax_ff == '0 && ay_ff == '0) ? absa_pkg::ST_IDLE : absa_pkg::ST_SQGO;
         end
         absa_pkg::ST_SQGO: state_in = absa_pkg::ST_SQRT;
         absa_pkg::ST_SQRT: if (!sq_busy) state_in = absa_pkg::ST_DVGO;
         absa_pkg::ST_DVGO: state_in = absa_pkg::ST_DIV;
         absa_pkg::ST_DIV:  if (dv_busy == 3'b000) state_in = absa_pkg::ST_FMUL;
         absa_pkg::ST_FMUL: state_in = absa_pkg::ST_TERM;
         absa_pkg::ST_TERM: state_in = absa_pkg::ST_RDA;
         absa_pkg::ST_RDA:  state_in = absa_pkg::ST_WRA;
         absa_pkg::ST_WRA:  state_in = absa_pkg::ST_RDB;
         absa_pkg::ST_RDB:  state_in = absa_pkg::ST_WRB;
         absa_pkg::ST_WRB:  state_in = absa_pkg::ST_IDLE;
         absa_pkg::ST_RRD:  state_in = absa_pkg::ST_RMUL;
         absa_pkg::ST_RMUL: state_in = absa_pkg::ST_RFIN;
         absa_pkg::ST_RFIN: state_in = absa_pkg::ST_ROUT;
         absa_pkg::ST_ROUT: if (!rsp_valid_ff || rsp_ready) state_in = absa_pkg::ST_IDLE;
         default:           state_in = absa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= absa_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == absa_pkg::ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign req_ready = (state_ff == absa_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) item_ff <= req_data;
   end

   // Bond geometry: differences, then squares and cross product.
   assign dx = {item_ff.pos_bx[31], item_ff.pos_bx} - {item_ff.pos_ax[31], item_ff.pos_ax};
   assign dy = {item_ff.pos_by[31], item_ff.pos_by} - {item_ff.pos_ay[31], item_ff.pos_ay};

   always_ff @(posedge clock) begin
      if (state_ff == absa_pkg::ST_DIFF) begin
         ax_ff    <= dx[32] ? 32'(0 - dx) : dx[31:0];
         ay_ff    <= dy[32] ? 32'(0 - dy) : dy[31:0];
         dxneg_ff <= dx[32];
         dyneg_ff <= dy[32];
      end
      if (state_ff == absa_pkg::ST_MUL) begin
         sx_ff  <= ax_ff * ax_ff;
         sy_ff  <= ay_ff * ay_ff;
         pxy_ff <= ax_ff * ay_ff;
      end
   end

   // Bond length, then the three quotients by it.
   assign sq_start = (state_ff == absa_pkg::ST_SQGO);
   assign dv_start = (state_ff == absa_pkg::ST_DVGO);
   assign dvnd[0]  = pxy_ff;
   assign dvnd[1]  = sy_ff;
   assign dvnd[2]  = sx_ff;

   absa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({1'b0, sx_ff} + {1'b0, sy_ff}),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   for (genvar k = 0; k < 3; k++) begin : g_div
      absa_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (dv_start),
         .dividend (dvnd[k]),
         .divisor  (sq_root),
         .busy     (dv_busy[k]),
         .quotient (quo[k])
      );
   end

   // Force times quotient, low 64 bits, in two 32-bit halves.
   assign fneg = active_force_ff[31];
   assign fm   = fneg ? 32'(0 - active_force_ff) : active_force_ff;

   always_ff @(posedge clock) begin
      if (state_ff == absa_pkg::ST_FMUL) begin
         for (int k = 0; k < 3; k++) begin
            plo_ff[k] <= fm * quo[k][31:0];
            phi_ff[k] <= 32'(fm * quo[k][63:32]);
         end
      end
   end

   // Term magnitudes carry the half and the Q32.16 scale in the shift.
   assign mxy   = 47'((plo_ff[0] + {phi_ff[0], 32'd0}) >> 17);
   assign myy   = 47'((plo_ff[1] + {phi_ff[1], 32'd0}) >> 17);
   assign mxx   = 47'((plo_ff[2] + {phi_ff[2], 32'd0}) >> 17);
   assign xyneg = fneg ^ dxneg_ff ^ dyneg_ff;

   always_ff @(posedge clock) begin
      if (state_ff == absa_pkg::ST_TERM) begin
         txy_ff <= xyneg ? 48'(0 - {1'b0, mxy}) : {1'b0, mxy};
         tyy_ff <= fneg  ? 48'(0 - {1'b0, myy}) : {1'b0, myy};
         txx_ff <= !fneg ? 48'(0 - {1'b0, mxx}) : {1'b0, mxx};
         tyx_ff <= !xyneg ? 48'(0 - {1'b0, mxy}) : {1'b0, mxy};
      end
   end

   // Updated entry for the read-modify-write of one bond atom.
   always_comb begin
      upd.comp_a = absa_pkg::sat_add(mem_rd_data.comp_a, txy_ff);
      upd.comp_b = absa_pkg::sat_add(mem_rd_data.comp_b, tyy_ff);
      upd.comp_c = absa_pkg::sat_add(mem_rd_data.comp_c, txx_ff);
      upd.comp_d = absa_pkg::sat_add(mem_rd_data.comp_d, tyx_ff);
   end

   // Memory port selection.
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = a_addr;
      mem_wr_en   = 1'b0;
      mem_wr_addr = a_addr;
      mem_wr_data = '0;
      case (state_ff)
         absa_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
         end
         absa_pkg::ST_RDA, absa_pkg::ST_RRD: mem_rd_en = 1'b1;
         absa_pkg::ST_RDB: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = b_addr;
         end
         absa_pkg::ST_WRA: begin
            mem_wr_en   = a_ok;
            mem_wr_data = upd;
         end
         absa_pkg::ST_WRB: begin
            mem_wr_en   = b_ok;
            mem_wr_addr = b_addr;
            mem_wr_data = upd;
         end
         absa_pkg::ST_RFIN: mem_wr_en = a_ok;
         default: ;
      endcase
   end

   absa_store #(
      .DEPTH (MAX_ATOMS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Readout scaling: magnitude times |pressure_scale|, split at bit 32.
   assign psneg   = pressure_scale_ff[31];
   assign psm     = psneg ? 32'(0 - pressure_scale_ff) : pressure_scale_ff;
   assign vals[0] = mem_rd_data.comp_a;
   assign vals[1] = mem_rd_data.comp_b;
   assign vals[2] = mem_rd_data.comp_c;
   assign vals[3] = mem_rd_data.comp_d;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         vmag[k]   = vals[k][47] ? 48'(0 - vals[k]) : vals[k];
         sprod[k]  = {shi_ff[k], 32'd0} + {16'd0, slo_ff[k]};
         scaled[k] = absa_pkg::sign_sat(sprod[k][79:16], !(vneg_ff[k] ^ psneg));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == absa_pkg::ST_RMUL) begin
         raw_ff <= mem_rd_data;
         for (int k = 0; k < 4; k++) begin
            slo_ff[k]  <= vmag[k][31:0] * psm;
            shi_ff[k]  <= vmag[k][47:32] * psm;
            vneg_ff[k] <= vals[k][47];
         end
      end
      if (state_ff == absa_pkg::ST_RFIN) begin
         if (!a_ok) begin
            res_ff <= '0;
         end else if (item_ff.in_group) begin
            res_ff <= {scaled[0], scaled[1], scaled[2], scaled[3]};
         end else begin
            res_ff <= raw_ff;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == absa_pkg::ST_ROUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == absa_pkg::ST_ROUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.out_atom  <= item_ff.atom_a;
         rsp_data_ff.stress_xy <= res_ff.comp_a;
         rsp_data_ff.stress_yy <= res_ff.comp_b;
         rsp_data_ff.stress_xx <= res_ff.comp_c;
         rsp_data_ff.stress_yx <= res_ff.comp_d;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ bench/tb.sv @@
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ATOM_COUNT = 4096;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   absa_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   absa_pkg::rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = absa_pkg::CSR_ACTIVE_FORCE;
   logic [31:0] csr_wdata = '0;

   active_bond_stress_accumulator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predicted stress table and register copies.
   absa_pkg::acc_type stress_xy_tab[ATOM_COUNT];
   absa_pkg::acc_type stress_yy_tab[ATOM_COUNT];
   absa_pkg::acc_type stress_xx_tab[ATOM_COUNT];
   absa_pkg::acc_type stress_yx_tab[ATOM_COUNT];
   logic [31:0] force_reg = absa_pkg::ACTIVE_FORCE_RESET;
   logic [31:0] scale_reg = absa_pkg::PRESSURE_SCALE_RESET;

   absa_pkg::req_type pending_items[$];
   absa_pkg::rsp_type expected_stress[$];
   int      error_count = 0;
   int      sender_idle_pct = 34;
   int      receiver_idle_pct = 74;
   logic    req_took = 1'b0;
   logic    hold_request = 1'b0;
   logic    hold_started = 1'b0;
   int      hold_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(3_000_000 * 12);
      $display("FAIL active_bond_stress_accumulator_core");
      $finish;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   function automatic logic [63:0] floor_root(input logic [65:0] rsq);
      logic [63:0]  res;
      logic [63:0]  cand;
      logic [131:0] prod;
      res = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         prod = 132'(cand) * 132'(cand);
         if (prod <= 132'(rsq)) begin
            res = cand;
         end
      end
      return res;
   endfunction

   // Applies a sign to a magnitude, saturating to 48 bits.
   function automatic absa_pkg::acc_type signed_term(input logic [63:0] m, input logic neg);
      logic [63:0] negm;
      negm = -m;
      if (neg) begin
         if (m >= 64'h0000_8000_0000_0000) return absa_pkg::ACC_MIN;
         return negm[47:0];
      end
      if (m > 64'h0000_7FFF_FFFF_FFFF) return absa_pkg::ACC_MAX;
      return m[47:0];
   endfunction

   function automatic absa_pkg::acc_type clamp_sum(input absa_pkg::acc_type a,
                                                   input absa_pkg::acc_type b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s > 49'sh0_7FFF_FFFF_FFFF) return absa_pkg::ACC_MAX;
      if (s < -49'sh0_8000_0000_0000) return absa_pkg::ACC_MIN;
      return s[47:0];
   endfunction

   function automatic absa_pkg::acc_type scaled_stress(input absa_pkg::acc_type v,
                                                       input logic grp);
      logic [127:0] prod;
      logic [63:0]  m;
      logic [47:0]  vm;
      logic [31:0]  pm;
      logic signed [31:0] ps;
      if (!grp) return v;
      ps = scale_reg;
      vm = v[47] ? 48'(-v) : 48'(v);
      pm = ps[31] ? 32'(-ps) : 32'(ps);
      prod = 128'(vm) * 128'(pm);
      m = (prod[127:80] != 0) ? '1 : prod[79:16];
      if (m == 0) return '0;
      return signed_term(m, (v[47] == ps[31]));
   endfunction

   // Adds one bond's four terms to both atoms.
   task automatic add_bond(input absa_pkg::req_type it);
      logic signed [32:0] dx, dy, ddx, ddy;
      logic [63:0] mx, my, sx, sy, r, fm, qxy, qyy, qxx;
      logic [65:0] rsq;
      logic        fneg, xyneg;
      absa_pkg::acc_type txy, tyy, txx, tyx;
      dx = {it.pos_bx[31], it.pos_bx} - {it.pos_ax[31], it.pos_ax};
      dy = {it.pos_by[31], it.pos_by} - {it.pos_ay[31], it.pos_ay};
      if (dx == 0 && dy == 0) return;
      ddx = dx[32] ? -dx : dx;
      ddy = dy[32] ? -dy : dy;
      mx = {31'b0, ddx};
      my = {31'b0, ddy};
      sx = mx * mx;
      sy = my * my;
      rsq = {2'b0, sx} + {2'b0, sy};
      r = floor_root(rsq);
      if (r == 0) return;
      fneg = force_reg[31];
      fm = fneg ? {32'b0, 32'(-force_reg)} : {32'b0, force_reg};
      qxy = (mx * my) / r;
      qyy = sy / r;
      qxx = sx / r;
      xyneg = fneg != (dx[32] != dy[32]);
      txy = signed_term((fm * qxy) >> 17, xyneg);
      tyy = signed_term((fm * qyy) >> 17, fneg);
      txx = signed_term((fm * qxx) >> 17, !fneg);
      tyx = signed_term((fm * qxy) >> 17, !xyneg);
      foreach (stress_xy_tab[i]) begin
         if (i == it.atom_a || i == it.atom_b) begin
            // A bond naming one atom twice adds to it twice.
            repeat ((i == it.atom_a && i == it.atom_b) ? 2 : 1) begin
               stress_xy_tab[i] = clamp_sum(stress_xy_tab[i], txy);
               stress_yy_tab[i] = clamp_sum(stress_yy_tab[i], tyy);
               stress_xx_tab[i] = clamp_sum(stress_xx_tab[i], txx);
               stress_yx_tab[i] = clamp_sum(stress_yx_tab[i], tyx);
            end
         end
      end
   endtask

   // Predicts the effect of one accepted transfer.
   task automatic predict_item(input absa_pkg::req_type it);
      absa_pkg::rsp_type res;
      if (it.mode == absa_pkg::MODE_READOUT) begin
         res.out_atom  = it.atom_a;
         res.stress_xy = scaled_stress(stress_xy_tab[it.atom_a], it.in_group);
         res.stress_yy = scaled_stress(stress_yy_tab[it.atom_a], it.in_group);
         res.stress_xx = scaled_stress(stress_xx_tab[it.atom_a], it.in_group);
         res.stress_yx = scaled_stress(stress_yx_tab[it.atom_a], it.in_group);
         stress_xy_tab[it.atom_a] = '0;
         stress_yy_tab[it.atom_a] = '0;
         stress_xx_tab[it.atom_a] = '0;
         stress_yx_tab[it.atom_a] = '0;
         expected_stress.push_back(res);
      end else begin
         add_bond(it);
      end
   endtask

   // Sender: holds the payload until the transfer completes.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off.
   always @(negedge clock) begin
      if (hold_request && !hold_started) begin
         hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: checks results, then predicts newly accepted transfers.
   always @(posedge clock) begin
      absa_pkg::rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stress.size() == 0) begin
               report("unexpected result", 64'(rsp_data.out_atom), 64'd0);
            end else begin
               want = expected_stress.pop_front();
               if (rsp_data.out_atom !== want.out_atom)
                  report("out_atom", 64'(rsp_data.out_atom), 64'(want.out_atom));
               if (rsp_data.stress_xy !== want.stress_xy)
                  report("stress_xy", 64'(rsp_data.stress_xy), 64'(want.stress_xy));
               if (rsp_data.stress_yy !== want.stress_yy)
                  report("stress_yy", 64'(rsp_data.stress_yy), 64'(want.stress_yy));
               if (rsp_data.stress_xx !== want.stress_xx)
                  report("stress_xx", 64'(rsp_data.stress_xx), 64'(want.stress_xx));
               if (rsp_data.stress_yx !== want.stress_yx)
                  report("stress_yx", 64'(rsp_data.stress_yx), 64'(want.stress_yx));
            end
         end
         if (req_valid && req_ready) begin
            req_took = 1'b1;
            predict_item(req_data);
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == absa_pkg::CSR_ACTIVE_FORCE) force_reg = value;
      else if (idx == absa_pkg::CSR_PRESSURE_SCALE) scale_reg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every item is sent and every result has come, then lets bonds finish.
   task automatic drain();
      while (pending_items.size() != 0 || expected_stress.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic absa_pkg::req_type bond_item(input logic [11:0] a, input logic [11:0] b,
                                         input logic [31:0] ax, input logic [31:0] ay,
                                         input logic [31:0] bx, input logic [31:0] by);
      absa_pkg::req_type it;
      it = '0;
      it.mode = absa_pkg::MODE_BOND;
      it.atom_a = a;
      it.atom_b = b;
      it.pos_ax = ax;
      it.pos_ay = ay;
      it.pos_bx = bx;
      it.pos_by = by;
      it.in_group = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic absa_pkg::req_type readout_item(input logic [11:0] a, input logic grp);
      absa_pkg::req_type it;
      it = '0;
      it.mode = absa_pkg::MODE_READOUT;
      it.atom_a = a;
      it.atom_b = 12'($urandom);
      it.pos_ax = $urandom;
      it.pos_ay = $urandom;
      it.pos_bx = $urandom;
      it.pos_by = $urandom;
      it.in_group = grp;
      return it;
   endfunction

   // Random item: mostly a small pool of atoms so readouts see accumulated stress.
   function automatic absa_pkg::req_type random_item(input int readout_pct);
      absa_pkg::req_type it;
      logic [11:0] a, b;
      logic [31:0] ax, ay;
      int          shape;
      a = ($urandom_range(0, 99) < 75) ? 12'($urandom_range(0, 7)) : 12'($urandom);
      b = ($urandom_range(0, 99) < 75) ? 12'($urandom_range(0, 7)) : 12'($urandom);
      if ($urandom_range(0, 9) == 0) b = a;
      if ($urandom_range(0, 99) < readout_pct)
         return readout_item(a, 1'($urandom_range(0, 1)));
      ax = $urandom;
      ay = $urandom;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         it = bond_item(a, b, ax, ay, ax, ay);
      end else if (shape < 5) begin
         it = bond_item(a, b, ax, ay,
                        ax + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19),
                        ay + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19));
      end else begin
         it = bond_item(a, b, ax, ay, $urandom, $urandom);
      end
      return it;
   endfunction

   initial begin
      logic [31:0] force_set[6];
      logic [31:0] scale_set[6];
      force_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, $urandom, 32'h0000_0001,
                    32'hFFFF_0000};
      scale_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, $urandom, 32'h0000_0000,
                    32'h0000_0001};
      foreach (stress_xy_tab[i]) begin
         stress_xy_tab[i] = '0;
         stress_yy_tab[i] = '0;
         stress_xx_tab[i] = '0;
         stress_yx_tab[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values of the registers: zero force adds nothing, unit scale at readout.
      pending_items.push_back(bond_item(12'd1, 12'd2, 32'd0, 32'd0, 32'h0003_0000, 32'h0004_0000));
      pending_items.push_back(readout_item(12'd1, 1'b1));
      pending_items.push_back(readout_item(12'd2, 1'b0));
      drain();

      // Directed: extreme positions and indices, zero-length bonds, same atom twice.
      write_csr(absa_pkg::CSR_ACTIVE_FORCE, 32'h7FFF_FFFF);
      pending_items.push_back(bond_item(12'd0, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000));
      pending_items.push_back(bond_item(12'd0, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h8000_0000));
      pending_items.push_back(bond_item(12'd5, 12'd5, 32'h0001_0000, 32'h0002_0000,
                                        32'h0004_0000, 32'hFFFE_0000));
      pending_items.push_back(bond_item(12'd6, 12'd7, 32'h1234_5678, 32'h8765_4321,
                                        32'h1234_5678, 32'h8765_4321));
      pending_items.push_back(bond_item(12'd8, 12'd8, 32'd0, 32'd0, 32'd0, 32'd1));
      pending_items.push_back(bond_item(12'd9, 12'd10, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
      repeat (6) begin
         pending_items.push_back(bond_item(12'd11, 12'd11, 32'h8000_0000, 32'h8000_0000,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF));
      end
      pending_items.push_back(readout_item(12'd0, 1'b0));
      pending_items.push_back(readout_item(12'd4095, 1'b1));
      pending_items.push_back(readout_item(12'd5, 1'b1));
      pending_items.push_back(readout_item(12'd6, 1'b0));
      pending_items.push_back(readout_item(12'd7, 1'b0));
      pending_items.push_back(readout_item(12'd8, 1'b1));
      pending_items.push_back(readout_item(12'd9, 1'b0));
      pending_items.push_back(readout_item(12'd11, 1'b0));
      pending_items.push_back(readout_item(12'd11, 1'b1));
      drain();

      // Random phases over several register settings and idle patterns.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2 || ph == 3) begin
            sender_idle_pct = 74;
            receiver_idle_pct = 34;
         end else if (ph >= 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         write_csr(absa_pkg::CSR_ACTIVE_FORCE, force_set[ph]);
         write_csr(absa_pkg::CSR_PRESSURE_SCALE, scale_set[ph]);
         if (ph == 4) begin
            // Readout-heavy burst against a long receiver hold-off.
            for (int k = 0; k < 40; k++) pending_items.push_back(random_item(90));
            hold_request = 1'b1;
         end
         for (int k = 0; k < 280; k++) pending_items.push_back(random_item(30));
         drain();
      end

      if (error_count == 0) begin
         $display("PASS active_bond_stress_accumulator_core");
      end else begin
         $display("FAIL active_bond_stress_accumulator_core");
      end
      $finish;
   end

endmodule
